### rtl/core/kmq_pkg.sv
// kmq_pkg: shared constants for the keyed message queue.
// Field widths, default parameter values and opcode codes.
// No dependencies.
`default_nettype none

package kmq_pkg;

   // fixed field widths of the request and response channels
   localparam int KMQ_OPCODE_W = 1;
   localparam int KMQ_KEY_W    = 64;
   localparam int KMQ_PAY_W    = 64;
   localparam int KMQ_HELD_W   = 5;

   // default values of the top-level parameters
   localparam int KMQ_DEPTH_DEF        = 16;
   localparam int KMQ_KEY_BITS_DEF     = 64;
   localparam int KMQ_PAYLOAD_BITS_DEF = 64;

   // request opcodes
   localparam logic [KMQ_OPCODE_W-1:0] KMQ_OP_POST  = 1'b0;
   localparam logic [KMQ_OPCODE_W-1:0] KMQ_OP_CHECK = 1'b1;

endpackage

`default_nettype wire

### rtl/core/kmq_ram.sv
// kmq_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module kmq_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/core/keyed_message_queue.sv
// A post into a non-full queue goes from idle through the append and done states.
// A post into a full queue first moves entries 1.. down one place, and a check
// scans entries from the oldest and closes the gap behind a hit; both read the
// entries one by one through the single RAM read port.
// Throughput: one request at a time; busy stays high until the response strobe.
// Responses last one cycle and cannot be stalled. Synchronous reset empties the
// queue (fill count to zero) and returns to idle; RAM contents are not cleared.
`default_nettype none

module keyed_message_queue #(
   parameter int QUEUE_DEPTH  = kmq_pkg::KMQ_DEPTH_DEF,
   parameter int KEY_BITS     = kmq_pkg::KMQ_KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = kmq_pkg::KMQ_PAYLOAD_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [kmq_pkg::KMQ_OPCODE_W-1:0] req_opcode,
   input  wire logic [kmq_pkg::KMQ_KEY_W-1:0]    req_event_key,
   input  wire logic [kmq_pkg::KMQ_PAY_W-1:0]    req_payload_in,
   output logic                                 rsp_strobe,
   output logic                                 rsp_found,
   output logic      [kmq_pkg::KMQ_PAY_W-1:0]    rsp_payload_out,
   output logic                                 rsp_dropped_oldest,
   output logic      [kmq_pkg::KMQ_HELD_W-1:0]   rsp_entries_held
);

   import kmq_pkg::*;

   localparam int IDX_W   = $clog2(QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = KEY_BITS + PAYLOAD_BITS;

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_SHIFT  = 3'd2;
   localparam logic [2:0] ST_APPEND = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;   // entries held, oldest at address 0
   logic [CNT_W-1:0]        ptr_ff, ptr_in;       // next address to read
   logic                    pend_ff, pend_in;     // a read was issued last cycle
   logic [CNT_W-1:0]        addr_ff, addr_in;     // address of that read
   logic [KMQ_OPCODE_W-1:0] op_ff, op_in;
   logic [KEY_BITS-1:0]     key_ff, key_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic                    found_ff, found_in;
   logic [PAYLOAD_BITS-1:0] pay_out_ff, pay_out_in;
   logic                    drop_ff, drop_in;

   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr;
   logic [ENTRY_W-1:0]      ram_wdata;
   logic [ENTRY_W-1:0]      ram_rdata;
   logic [CNT_W-1:0]        dest_addr;
   logic                    more;
   logic                    rd_hit;

   // one RAM holds {key, payload} per entry
   kmq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH),
      .ADDR_W(IDX_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ptr_ff[IDX_W-1:0]),
      .rd_data(ram_rdata)
   );

   // entries left to read, and compare of the entry read last cycle
   assign more      = (ptr_ff < count_ff);
   assign rd_hit    = pend_ff && (ram_rdata[ENTRY_W-1:PAYLOAD_BITS] == key_ff);
   // during compaction the entry read from address a moves to a-1
   assign dest_addr = addr_ff - CNT_W'(1);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      pend_in    = 1'b0;
      addr_in    = addr_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      pay_in     = pay_ff;
      found_in   = found_ff;
      pay_out_in = pay_out_ff;
      drop_in    = drop_ff;
      ram_we     = 1'b0;
      ram_waddr  = '0;
      ram_wdata  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // capture the request and clear the response fields
               op_in      = req_opcode;
               key_in     = req_event_key[KEY_BITS-1:0];
               pay_in     = req_payload_in[PAYLOAD_BITS-1:0];
               found_in   = 1'b0;
               pay_out_in = '0;
               drop_in    = 1'b0;
               if (req_opcode == KMQ_OP_CHECK) begin
                  ptr_in   = '0;
                  state_in = ST_SCAN;
               end else if (count_ff == CNT_W'(QUEUE_DEPTH)) begin
                  // full: drop the oldest by moving entries 1.. down one place
                  ptr_in   = CNT_W'(1);
                  drop_in  = 1'b1;
                  state_in = ST_SHIFT;
               end else begin
                  state_in = ST_APPEND;
               end
            end
         end

         ST_SCAN: begin
            if (rd_hit) begin
               // take the oldest match, then close the gap behind it
               found_in   = 1'b1;
               pay_out_in = ram_rdata[PAYLOAD_BITS-1:0];
               ptr_in     = addr_ff + CNT_W'(1);
               state_in   = ST_SHIFT;
            end else if (more) begin
               pend_in = 1'b1;
               addr_in = ptr_ff;
               ptr_in  = ptr_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               state_in = ST_DONE;
            end
         end

         ST_SHIFT: begin
            if (pend_ff) begin
               ram_we    = 1'b1;
               ram_waddr = dest_addr[IDX_W-1:0];
               ram_wdata = ram_rdata;
            end
            if (more) begin
               pend_in = 1'b1;
               addr_in = ptr_ff;
               ptr_in  = ptr_ff + CNT_W'(1);
            end else if (!pend_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = (op_ff == KMQ_OP_POST) ? ST_APPEND : ST_DONE;
            end
         end

         ST_APPEND: begin
            ram_we    = 1'b1;
            ram_waddr = count_ff[IDX_W-1:0];
            ram_wdata = {key_ff, pay_ff};
            count_in  = count_ff + CNT_W'(1);
            state_in  = ST_DONE;
         end

         ST_DONE: begin
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      addr_ff    <= addr_in;
      op_ff      <= op_in;
      key_ff     <= key_in;
      pay_ff     <= pay_in;
      found_ff   <= found_in;
      pay_out_ff <= pay_out_in;
      drop_ff    <= drop_in;
   end

   // hold the response on the ports during the single done cycle
   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = (state_ff == ST_DONE);
   assign rsp_found          = found_ff;
   assign rsp_payload_out    = KMQ_PAY_W'(pay_out_ff);
   assign rsp_dropped_oldest = drop_ff;
   assign rsp_entries_held   = KMQ_HELD_W'(count_ff);

endmodule

`default_nettype wire

### rtl/core/kmq_checker.sv
// kmq_checker: port-level assertions for keyed_message_queue, and its bind.
// Uses kmq_pkg for field widths.
`default_nettype none

module kmq_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic                             rsp_strobe,
   input wire logic                             rsp_found,
   input wire logic [kmq_pkg::KMQ_PAY_W-1:0]     rsp_payload_out,
   input wire logic                             rsp_dropped_oldest
);

   // an accepted request keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but block not busy next cycle");

   // one response per request: strobe never stays high on back-to-back edges
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   // a response only comes while a request is in progress
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("response strobe while idle");

   // a hit never also drops an entry
   a_hit_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_found |-> !rsp_dropped_oldest)
      else $error("found and dropped_oldest both set");

   // a miss or a post returns a zero payload
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_found |-> rsp_payload_out == '0)
      else $error("nonzero payload without a hit");

endmodule

bind keyed_message_queue kmq_checker u_kmq_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_strobe        (rsp_strobe),
   .rsp_found         (rsp_found),
   .rsp_payload_out   (rsp_payload_out),
   .rsp_dropped_oldest(rsp_dropped_oldest)
);

`default_nettype wire

### bench/keyed_message_queue_checker.sv
// keyed_message_queue_checker: watches the request and response channels of the
// keyed message queue, predicts each response and compares all of its fields.
// Depends on kmq_pkg for field widths, default parameters and opcodes.
`timescale 1ns / 1ps

module keyed_message_queue_checker #(
   parameter int QUEUE_DEPTH  = kmq_pkg::KMQ_DEPTH_DEF,
   parameter int KEY_BITS     = kmq_pkg::KMQ_KEY_BITS_DEF,
   parameter int PAYLOAD_BITS = kmq_pkg::KMQ_PAYLOAD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic [kmq_pkg::KMQ_OPCODE_W-1:0]   req_opcode,
   input  logic [kmq_pkg::KMQ_KEY_W-1:0]      req_event_key,
   input  logic [kmq_pkg::KMQ_PAY_W-1:0]      req_payload_in,
   input  logic                               rsp_strobe,
   input  logic                               rsp_found,
   input  logic [kmq_pkg::KMQ_PAY_W-1:0]      rsp_payload_out,
   input  logic                               rsp_dropped_oldest,
   input  logic [kmq_pkg::KMQ_HELD_W-1:0]     rsp_entries_held,
   output int                                 mismatch_count,
   output int                                 pending_count
);

   localparam logic [kmq_pkg::KMQ_KEY_W-1:0] KEY_MASK =
      {kmq_pkg::KMQ_KEY_W{1'b1}} >> (kmq_pkg::KMQ_KEY_W - KEY_BITS);
   localparam logic [kmq_pkg::KMQ_PAY_W-1:0] PAY_MASK =
      {kmq_pkg::KMQ_PAY_W{1'b1}} >> (kmq_pkg::KMQ_PAY_W - PAYLOAD_BITS);

   typedef struct packed {
      logic                           found;
      logic [kmq_pkg::KMQ_PAY_W-1:0]  payload;
      logic                           dropped;
      logic [kmq_pkg::KMQ_HELD_W-1:0] held;
   } reply_type;

   // oldest entry at index 0
   logic [kmq_pkg::KMQ_KEY_W-1:0] queued_keys[$];
   logic [kmq_pkg::KMQ_PAY_W-1:0] queued_payloads[$];
   reply_type                     expected_replies[$];
   int                            fail_tally = 0;
   int                            reply_index = 0;

   function automatic reply_type step_mailbox(
      input logic [kmq_pkg::KMQ_OPCODE_W-1:0] op,
      input logic [kmq_pkg::KMQ_KEY_W-1:0]    key_raw,
      input logic [kmq_pkg::KMQ_PAY_W-1:0]    pay_raw);
      reply_type                     r;
      int                            hit_at;
      logic [kmq_pkg::KMQ_KEY_W-1:0] key;
      int unsigned                   held;
      r = '0;
      hit_at = -1;
      key = key_raw & KEY_MASK;
      if (op == kmq_pkg::KMQ_OP_POST) begin
         // a full queue loses its oldest entry before the append
         if (queued_keys.size() >= QUEUE_DEPTH) begin
            void'(queued_keys.pop_front());
            void'(queued_payloads.pop_front());
            r.dropped = 1'b1;
         end
         queued_keys.push_back(key);
         queued_payloads.push_back(pay_raw & PAY_MASK);
      end else begin
         // the oldest matching entry wins
         for (int i = 0; i < queued_keys.size(); i++)
            if (hit_at < 0 && queued_keys[i] == key) hit_at = i;
         if (hit_at >= 0) begin
            r.found = 1'b1;
            r.payload = queued_payloads[hit_at];
            queued_keys.delete(hit_at);
            queued_payloads.delete(hit_at);
         end
      end
      held = queued_keys.size();
      r.held = held[kmq_pkg::KMQ_HELD_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (reset) begin
         queued_keys.delete();
         queued_payloads.delete();
         expected_replies.delete();
      end else begin
         // compare a response before predicting the next request
         if (rsp_strobe) begin
            got = {rsp_found, rsp_payload_out, rsp_dropped_oldest, rsp_entries_held};
            if (expected_replies.size() == 0) begin
               fail_tally++;
               if (fail_tally <= 10)
                  $display({"%0t: response with no request outstanding: ",
                            "found=%0b pay=%h drop=%0b held=%0d"},
                           $realtime, got.found, got.payload, got.dropped, got.held);
            end else begin
               want = expected_replies.pop_front();
               if (got !== want) begin
                  fail_tally++;
                  if (fail_tally <= 10)
                     $display({"%0t: response %0d mismatch: ",
                               "expected found=%0b pay=%h drop=%0b held=%0d, ",
                               "got found=%0b pay=%h drop=%0b held=%0d"},
                              $realtime, reply_index, want.found, want.payload,
                              want.dropped, want.held, got.found, got.payload,
                              got.dropped, got.held);
               end
            end
            reply_index++;
         end
         if (start && !busy)
            expected_replies.push_back(step_mailbox(req_opcode, req_event_key, req_payload_in));
      end
      mismatch_count <= fail_tally;
      pending_count  <= expected_replies.size();
   end

endmodule

### bench/tb.sv
// tb: stimulus and verdict for the keyed message queue.
// Depends on kmq_pkg, keyed_message_queue and keyed_message_queue_checker.
`timescale 1ns / 1ps

module tb;

   localparam int DEPTH       = kmq_pkg::KMQ_DEPTH_DEF;
   localparam int STALL_LIMIT = 4000;
   localparam int NUM_PHASES  = 7;
   localparam int PHASE_ITEMS = 200;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             start = 1'b0;
   logic                             busy;
   logic [kmq_pkg::KMQ_OPCODE_W-1:0] req_opcode = kmq_pkg::KMQ_OP_POST;
   logic [kmq_pkg::KMQ_KEY_W-1:0]    req_event_key = '0;
   logic [kmq_pkg::KMQ_PAY_W-1:0]    req_payload_in = '0;
   logic                             rsp_strobe;
   logic                             rsp_found;
   logic [kmq_pkg::KMQ_PAY_W-1:0]    rsp_payload_out;
   logic                             rsp_dropped_oldest;
   logic [kmq_pkg::KMQ_HELD_W-1:0]   rsp_entries_held;
   int                               mismatch_count;
   int                               pending_count;
   int                               quiet_cycles = 0;

   // when set, the sender never inserts idle cycles
   logic                             steady_stream = 1'b0;
   logic [kmq_pkg::KMQ_KEY_W-1:0]    key_pool[8];

   always #2 clock = ~clock;

   keyed_message_queue DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_event_key      (req_event_key),
      .req_payload_in     (req_payload_in),
      .rsp_strobe         (rsp_strobe),
      .rsp_found          (rsp_found),
      .rsp_payload_out    (rsp_payload_out),
      .rsp_dropped_oldest (rsp_dropped_oldest),
      .rsp_entries_held   (rsp_entries_held)
   );

   keyed_message_queue_checker checker_inst (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_event_key      (req_event_key),
      .req_payload_in     (req_payload_in),
      .rsp_strobe         (rsp_strobe),
      .rsp_found          (rsp_found),
      .rsp_payload_out    (rsp_payload_out),
      .rsp_dropped_oldest (rsp_dropped_oldest),
      .rsp_entries_held   (rsp_entries_held),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count)
   );

   // Count edges at which neither a request nor a response moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   // Watchdog: end the run if the handshakes stop moving.
   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Mostly reuse a small set of event names so that checks hit; now and then
   // send an arbitrary 64-bit key to exercise every key bit.
   function automatic logic [63:0] pick_key();
      if ($urandom_range(99) < 85) return key_pool[$urandom_range(7)];
      return random_word();
   endfunction

   // Present one request and hold it until the queue takes it. Start stays
   // high afterward, so back-to-back requests need no extra edge.
   task automatic issue_request(input logic [kmq_pkg::KMQ_OPCODE_W-1:0] op,
                                input logic [63:0] key, input logic [63:0] pay);
      while (!steady_stream && $urandom_range(99) < 27) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_event_key  <= key;
      req_payload_in <= pay;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and hold off until every predicted response has come back.
   task automatic wait_for_quiet();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned post_bias[NUM_PHASES];
      int unsigned name_len;
      post_bias = '{50, 80, 25, 55, 92, 15, 50};

      // Build the event name pool: zero-padded ASCII strings of random length,
      // plus two arbitrary words.
      for (int k = 0; k < 6; k++) begin
         key_pool[k] = '0;
         name_len = $urandom_range(1, 8);
         for (int b = 0; b < name_len; b++)
            key_pool[k][8*b +: 8] = 8'($urandom_range(8'h61, 8'h7a));
      end
      key_pool[6] = random_word();
      key_pool[7] = random_word();

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      // Check on an empty queue: a miss.
      issue_request(kmq_pkg::KMQ_OP_CHECK, 64'h0000_0000_0074_7665, random_word());
      // Field extremes: all-zero and all-one key and payload.
      issue_request(kmq_pkg::KMQ_OP_POST, '0, '0);
      issue_request(kmq_pkg::KMQ_OP_POST, '1, '1);
      issue_request(kmq_pkg::KMQ_OP_CHECK, '1, '0);
      // Duplicate keys: the check takes the older one and leaves the newer.
      issue_request(kmq_pkg::KMQ_OP_POST, 64'h0000_0000_6b63_6974, 64'h1111_2222_3333_4444);
      issue_request(kmq_pkg::KMQ_OP_POST, 64'h0000_0000_6b63_6974, 64'h5555_6666_7777_8888);
      issue_request(kmq_pkg::KMQ_OP_CHECK, 64'h0000_0000_6b63_6974, '1);
      // Fill to capacity, then post once more so the oldest entry is dropped.
      for (int i = 0; i < DEPTH - 2; i++)
         issue_request(kmq_pkg::KMQ_OP_POST, 64'h0000_0000_0065_7600 | 64'(i), random_word());
      issue_request(kmq_pkg::KMQ_OP_POST, 64'h0000_0000_0064_6f72, random_word());
      // Miss on a full queue: the entries stay put.
      issue_request(kmq_pkg::KMQ_OP_CHECK, 64'h0000_0000_0000_0000, random_word());
      wait_for_quiet();

      // Random part: most phases lean toward posts or checks so the queue
      // swings between empty and full; one phase runs with no idle cycles.
      for (int p = 0; p < NUM_PHASES; p++) begin
         steady_stream = (p == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(99) < post_bias[p])
               issue_request(kmq_pkg::KMQ_OP_POST, pick_key(), random_word());
            else
               issue_request(kmq_pkg::KMQ_OP_CHECK, pick_key(), random_word());
         end
         wait_for_quiet();
      end

      // Let any late activity surface before the verdict.
      repeat (2 * DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
